[sv/hsvrgb_pkg.sv]
// Shared constants, sector and distance types for the HSV to RGB pipeline.
package hsvrgb_pkg;

  localparam int unsigned HueW    = 9;
  localparam int unsigned FracW   = 9;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned DistW   = 6;   // 0..60
  localparam int unsigned KW      = 14;  // 0..15360
  localparam int unsigned ProdW   = 22;  // 0..3932160
  localparam int unsigned ScaledW = 30;  // 255 * product
  localparam int unsigned QW      = ScaledW - 16;
  localparam int unsigned RecipW  = 15;
  localparam int unsigned RecipSh = 20;

  localparam logic [HueW-1:0]    HueMax   = 9'd359;
  localparam logic [FracW-1:0]   FracOne  = 9'd256;
  localparam logic [DistW-1:0]   SecDeg   = 6'd60;
  localparam logic [KW-1:0]      KFull    = 14'd15360;   // 256 * 60
  localparam logic [RecipW-1:0]  Recip60  = 15'd17477;   // ceil(2^20 / 60)
  localparam logic [ChanW-1:0]   ChanMax  = 8'd255;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // per-channel weight distance: chroma channel 0, secondary dist, empty 60
  typedef struct packed {
    logic [DistW-1:0] r;
    logic [DistW-1:0] g;
    logic [DistW-1:0] b;
  } chan_dist_t;

endpackage

[sv/hsvrgb_front.sv]
// Input clamping, hue sector decode and per-channel weight distance.
module hsvrgb_front (
  input  logic [hsvrgb_pkg::HueW-1:0]  hue,
  input  logic [hsvrgb_pkg::FracW-1:0] saturation,
  input  logic [hsvrgb_pkg::FracW-1:0] brightness,
  output logic [hsvrgb_pkg::FracW-1:0] sat_clamp,
  output logic [hsvrgb_pkg::FracW-1:0] bri_clamp,
  output hsvrgb_pkg::chan_dist_t       wdist
);
  import hsvrgb_pkg::*;

  logic [HueW-1:0]  h;
  logic [HueW-1:0]  hm;
  logic [DistW-1:0] dd;
  sector_t          sector;

  always_comb begin
    h         = (hue > HueMax) ? HueMax : hue;
    sat_clamp = (saturation > FracOne) ? FracOne : saturation;
    bri_clamp = (brightness > FracOne) ? FracOne : brightness;

    if (h >= 9'd300)      sector = SEC_MR;
    else if (h >= 9'd240) sector = SEC_BM;
    else if (h >= 9'd180) sector = SEC_CB;
    else if (h >= 9'd120) sector = SEC_GC;
    else if (h >= 9'd60)  sector = SEC_YG;
    else                  sector = SEC_RY;

    // hue mod 120
    if (h >= 9'd240)      hm = h - 9'd240;
    else if (h >= 9'd120) hm = h - 9'd120;
    else                  hm = h;

    if (hm >= {3'd0, SecDeg}) dd = DistW'(hm - {3'd0, SecDeg});
    else                      dd = DistW'({3'd0, SecDeg} - hm);

    unique case (sector)
      SEC_RY: wdist = '{r: '0,     g: dd,     b: SecDeg};
      SEC_YG: wdist = '{r: dd,     g: '0,     b: SecDeg};
      SEC_GC: wdist = '{r: SecDeg, g: '0,     b: dd};
      SEC_CB: wdist = '{r: SecDeg, g: dd,     b: '0};
      SEC_BM: wdist = '{r: dd,     g: SecDeg, b: '0};
      SEC_MR: wdist = '{r: '0,     g: SecDeg, b: dd};
      default: wdist = '{r: SecDeg, g: SecDeg, b: SecDeg};
    endcase
  end

endmodule

[sv/hsvrgb_chan.sv]
// Four-stage scaling pipe for one channel: floor(255*v*(15360 - s*d) / 3932160).
module hsvrgb_chan (
  input  logic                         clk,
  input  logic [3:0]                   en,
  input  logic [hsvrgb_pkg::FracW-1:0] sat,
  input  logic [hsvrgb_pkg::FracW-1:0] bri,
  input  logic [hsvrgb_pkg::DistW-1:0] wdist,
  output logic [hsvrgb_pkg::ChanW-1:0] chan
);
  import hsvrgb_pkg::*;

  logic [KW-1:0]             k;
  logic [FracW-1:0]          bri2;
  logic [ProdW-1:0]          prod;
  logic [QW-1:0]             q;
  logic [KW-1:0]             sd;
  logic [ScaledW-1:0]        scaled;
  logic [QW+RecipW-1:0]      qm;
  logic [QW+RecipW-RecipSh-1:0] quot;

  always_comb begin
    sd     = KW'(sat) * KW'(wdist);
    scaled = ({prod, 8'd0}) - ScaledW'(prod);
    qm     = (QW+RecipW)'(q) * (QW+RecipW)'(Recip60);
    quot   = qm[QW+RecipW-1:RecipSh];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k    <= KFull - sd;
      bri2 <= bri;
    end
    if (en[1]) begin
      prod <= ProdW'(bri2) * ProdW'(k);
    end
    if (en[2]) begin
      q <= scaled[ScaledW-1:16];
    end
    if (en[3]) begin
      chan <= (quot > {1'b0, ChanMax}) ? ChanMax : quot[ChanW-1:0];
    end
  end

endmodule

[sv/hsv_to_rgb_converter_unit.sv]
// HSV to RGB converter top level: five-stage pipeline with per-stage valid bits.
// An input transfer reaches out_valid after passing through every stage register in order.
// Throughput: one color per cycle; a stalled output only fills empty stages behind it.
// Stages: clamp/sector, s*d, v*K, scale by 255, divide by 60 via reciprocal multiply.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
module hsv_to_rgb_converter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsvrgb_pkg::HueW-1:0]  hue,
  input  logic [hsvrgb_pkg::FracW-1:0] saturation,
  input  logic [hsvrgb_pkg::FracW-1:0] brightness,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsvrgb_pkg::ChanW-1:0] red,
  output logic [hsvrgb_pkg::ChanW-1:0] green,
  output logic [hsvrgb_pkg::ChanW-1:0] blue
);
  import hsvrgb_pkg::*;

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] adv;

  logic [FracW-1:0] sat_c;
  logic [FracW-1:0] bri_c;
  chan_dist_t       dist_c;

  logic [FracW-1:0] sat1;
  logic [FracW-1:0] bri1;
  chan_dist_t       dist1;

  // a stage takes new data when it is empty or its contents move on
  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || out_ready;
    for (int i = Stages-2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  hsvrgb_front u_front (
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sat_clamp  (sat_c),
    .bri_clamp  (bri_c),
    .wdist      (dist_c)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sat1  <= sat_c;
      bri1  <= bri_c;
      dist1 <= dist_c;
    end
  end

  hsvrgb_chan u_red (
    .clk   (clk),
    .en    (adv[Stages-1:1]),
    .sat   (sat1),
    .bri   (bri1),
    .wdist (dist1.r),
    .chan  (red)
  );

  hsvrgb_chan u_green (
    .clk   (clk),
    .en    (adv[Stages-1:1]),
    .sat   (sat1),
    .bri   (bri1),
    .wdist (dist1.g),
    .chan  (green)
  );

  hsvrgb_chan u_blue (
    .clk   (clk),
    .en    (adv[Stages-1:1]),
    .sat   (sat1),
    .bri   (bri1),
    .wdist (dist1.b),
    .chan  (blue)
  );

  // an input transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("input transfer not captured in first stage");

  // with the output free to drain, the whole pipe moves
  a_drain_free: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is accepted");

  // backpressure at the input only comes from a full pipe behind a held output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (vld == '1) && !out_ready)
    else $error("input stalled with a bubble in the pipe");

  // an item in the next-to-last stage reaches the output when it is empty
  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
    vld[Stages-2] && !vld[Stages-1] |=> vld[Stages-1])
    else $error("item did not advance into empty output stage");

endmodule
